>>> hw/rtl/kwa_pkg.sv
`timescale 1ns / 1ps

package kwa_pkg;

	localparam int unsigned KEY_COUNT = 16;
	localparam int unsigned AGE_W = 6;
	localparam int unsigned SPAN_W = 5;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 5;

	localparam logic [AGE_W-1:0] AGE_MAX = 6'd63;

	localparam logic [CFG_INDEX_W-1:0] REG_PAD_ENABLED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DELAY = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NEXT_DELAY = 2'd2;

	localparam logic PAD_ENABLED_RST = 1'b1;
	localparam logic [SPAN_W-1:0] FIRST_DELAY_RST = 5'd20;
	localparam logic [SPAN_W-1:0] NEXT_DELAY_RST = 5'd5;

	typedef logic [KEY_COUNT-1:0] key_mask_t;

	typedef struct packed {
		key_mask_t keys_now;
		key_mask_t keys_before;
		key_mask_t repeat_key;
		key_mask_t hidden_keys;
		logic [AGE_W-1:0] frame_age;
		logic [SPAN_W-1:0] repeat_span;
	} pad_state_t;

	typedef struct packed {
		logic pad_enabled;
		logic [SPAN_W-1:0] first_repeat_delay;
		logic [SPAN_W-1:0] next_repeat_delay;
	} pad_cfg_t;

	typedef struct packed {
		logic key_caught;
		logic [INDEX_W-1:0] key_slot;
		key_mask_t held_mask;
	} pad_result_t;

	function automatic logic [INDEX_W-1:0] lowest_index(input key_mask_t mask);
		logic [INDEX_W-1:0] idx;
		idx = '0;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = INDEX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> hw/rtl/kwa_frame.sv
`timescale 1ns / 1ps

module kwa_frame (
	input  kwa_pkg::pad_state_t  cur,
	input  kwa_pkg::pad_cfg_t    cfg,
	input  kwa_pkg::key_mask_t   key_sample,
	input  logic                 catch_request,
	output kwa_pkg::pad_state_t  nxt,
	output kwa_pkg::pad_result_t res
);

	kwa_pkg::pad_state_t st;
	kwa_pkg::key_mask_t press;
	kwa_pkg::key_mask_t fresh;
	kwa_pkg::key_mask_t cand;
	logic caught;

	always_comb begin
		st = cur;
		press = '0;
		fresh = '0;
		cand = '0;
		caught = 1'b0;

		if (cur.frame_age != kwa_pkg::AGE_MAX) begin
			st.frame_age = cur.frame_age + 1'b1;
		end

		if (cfg.pad_enabled) begin
			st.keys_before = cur.keys_now;
			st.keys_now = key_sample;
			st.hidden_keys = cur.hidden_keys & ~(cur.keys_now ^ key_sample);
			st.repeat_key = cur.repeat_key & st.hidden_keys;
		end

		if (cfg.pad_enabled && catch_request) begin
			if (st.frame_age >= {1'b0, st.repeat_span}) begin
				st.keys_before = st.keys_before & ~st.repeat_key;
			end
			press = st.keys_now & ~st.keys_before;
			if (press != '0) begin
				fresh = press & ~st.repeat_key;
				cand = (fresh != '0) ? fresh : st.repeat_key;
				st.hidden_keys = st.hidden_keys | cand;
				st.frame_age = '0;
				st.repeat_span = (cand != st.repeat_key) ? cfg.first_repeat_delay
					: cfg.next_repeat_delay;
				st.repeat_key = cand & (~cand + 1'b1);
				caught = 1'b1;
			end
		end
	end

	assign nxt = st;
	assign res.key_caught = caught;
	assign res.key_slot = caught ? kwa_pkg::lowest_index(st.repeat_key) : '0;
	assign res.held_mask = st.keys_now & ~st.hidden_keys;

endmodule

>>> hw/rtl/keypad_wait_with_autorepeat_unit.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid, in_ready   | key_sample, catch_request
// out      | out_valid, out_ready | key_caught, key_slot, held_mask
// cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// One frame beat is taken per cycle while in_ready is high; it passes the input register, then the result register.
// The frame logic is combinational between the input register and the result register.
// Reset restores the default delays, enables the pad and saturates the frame age.
// A stalled result holds the result register and, once the input register is full, in_ready.

module keypad_wait_with_autorepeat_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [kwa_pkg::KEY_COUNT-1:0]        key_sample,
	input  logic                                 catch_request,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 key_caught,
	output logic [kwa_pkg::INDEX_W-1:0]          key_slot,
	output logic [kwa_pkg::KEY_COUNT-1:0]        held_mask,
	input  logic                                 cfg_wr_en,
	input  logic [kwa_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [kwa_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic valid_s1;
	kwa_pkg::key_mask_t key_sample_s1;
	logic catch_request_s1;
	logic advance;

	kwa_pkg::pad_state_t state_q;
	kwa_pkg::pad_state_t state_nxt;
	kwa_pkg::pad_cfg_t cfg_q;
	kwa_pkg::pad_result_t res_nxt;
	kwa_pkg::pad_result_t res_q;
	logic out_valid_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_sample_s1 <= key_sample;
			catch_request_s1 <= catch_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pad_enabled <= kwa_pkg::PAD_ENABLED_RST;
			cfg_q.first_repeat_delay <= kwa_pkg::FIRST_DELAY_RST;
			cfg_q.next_repeat_delay <= kwa_pkg::NEXT_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kwa_pkg::REG_PAD_ENABLED: cfg_q.pad_enabled <= cfg_data[0];
				kwa_pkg::REG_FIRST_DELAY: cfg_q.first_repeat_delay <= cfg_data;
				kwa_pkg::REG_NEXT_DELAY: cfg_q.next_repeat_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	kwa_frame u_frame (
		.cur           (state_q),
		.cfg           (cfg_q),
		.key_sample    (key_sample_s1),
		.catch_request (catch_request_s1),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.keys_now <= '0;
			state_q.keys_before <= '0;
			state_q.repeat_key <= '0;
			state_q.hidden_keys <= '0;
			state_q.frame_age <= kwa_pkg::AGE_MAX;
			state_q.repeat_span <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign key_caught = res_q.key_caught;
	assign key_slot = res_q.key_slot;
	assign held_mask = res_q.held_mask;

endmodule
